// ===== sv/tbp_pkg.sv =====
package tbp_pkg;

   typedef logic [1:0] ctr_type;

   localparam ctr_type CTR_MAX   = 2'd3;
   localparam ctr_type CTR_ZERO  = 2'd0;
   localparam int      CTR_UPPER = 1;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SLOT,
      ST_LOCAL
   } state_type;

   function automatic ctr_type sat_count(input ctr_type c, input logic up);
      ctr_type r;
      r = c;
      if (up) begin
         if (c != CTR_MAX) r = c + 2'd1;
      end else begin
         if (c != CTR_ZERO) r = c - 2'd1;
      end
      return r;
   endfunction

endpackage

// ===== sv/tbp_train.sv =====
module tbp_train
   import tbp_pkg::*;
#(
   parameter int INDEX_BITS = 10
) (
   input  logic [INDEX_BITS-1:0] hist,
   input  ctr_type               sel,
   input  ctr_type               addr_ctr,
   input  ctr_type               loc_ctr,
   input  logic                  taken,
   output logic                  pred,
   output logic                  use_addr,
   output logic [INDEX_BITS-1:0] hist_next,
   output ctr_type               sel_next,
   output ctr_type               addr_next,
   output ctr_type               loc_next
);

   logic            addr_pred;
   logic            loc_pred;
   logic [INDEX_BITS:0] shifted;

   assign use_addr  = sel[CTR_UPPER];
   assign addr_pred = addr_ctr[CTR_UPPER];
   assign loc_pred  = loc_ctr[CTR_UPPER];
   assign pred      = use_addr ? addr_pred : loc_pred;

   // shift outcome in, drop the oldest bit
   assign shifted   = {hist, taken};
   assign hist_next = shifted[INDEX_BITS-1:0];

   always_comb begin
      if (use_addr) begin
         sel_next  = sat_count(sel, addr_pred == taken);
         addr_next = sat_count(addr_ctr, taken);
         loc_next  = loc_ctr;
      end else begin
         sel_next  = sat_count(sel, loc_pred != taken);
         addr_next = addr_ctr;
         loc_next  = sat_count(loc_ctr, taken);
      end
   end

endmodule

// ===== sv/tournament_branch_predictor_unit.sv =====
// Tournament branch predictor. Each word on req_ either asks for a prediction
// (operation 0) or also trains the tables with the real outcome (operation 1);
// every word yields exactly one rsp_ word holding the prediction made from the
// state before it. The per-slot table (history, address counter, selector) is
// read at the accepting edge, the local counter table is read at that history
// in the cycle after, and the prediction lands in the result register with the
// write-back in the ST_LOCAL stage once the output register is free. A new word
// is accepted only back in ST_IDLE, after the last one has been written back; a
// result still waiting in the output register holds the write-back stage. After
// reset the block sweeps both tables to zero, one entry a cycle, and holds
// req_ready low meanwhile.
module tournament_branch_predictor_unit
   import tbp_pkg::*;
#(
   parameter int INDEX_BITS = 10
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_operation,
   input  logic [31:0] req_branch_address,
   input  logic        req_actual_taken,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_predict_taken,
   output logic        rsp_chose_address_side
);

   localparam int DEPTH      = 1 << INDEX_BITS;
   localparam int SLOT_WIDTH = INDEX_BITS + 4;

   // slot entry: {history, address counter, selector}
   logic [SLOT_WIDTH-1:0] slot_mem [DEPTH];
   ctr_type               local_mem [DEPTH];

   state_type             state_ff, state_in;
   logic [INDEX_BITS-1:0] clr_ff, clr_in;
   logic                  op_ff;
   logic                  taken_ff;
   logic [INDEX_BITS-1:0] slot_ff;
   logic [SLOT_WIDTH-1:0] slot_rdata_ff;
   ctr_type               local_rdata_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_pred_ff;
   logic                  rsp_addr_ff;

   logic                  accept;
   logic                  advance;
   logic                  slot_we;
   logic [INDEX_BITS-1:0] slot_waddr;
   logic [SLOT_WIDTH-1:0] slot_wdata;
   logic                  local_we;
   logic [INDEX_BITS-1:0] local_waddr;
   ctr_type               local_wdata;
   logic                  slot_re;
   logic                  local_re;

   logic [INDEX_BITS-1:0] hist;
   ctr_type               sel;
   ctr_type               addr_ctr;
   logic                  pred;
   logic                  use_addr;
   logic [INDEX_BITS-1:0] hist_next;
   ctr_type               sel_next;
   ctr_type               addr_next;
   ctr_type               loc_next;

   assign hist     = slot_rdata_ff[SLOT_WIDTH-1:4];
   assign addr_ctr = slot_rdata_ff[3:2];
   assign sel      = slot_rdata_ff[1:0];

   tbp_train #(
      .INDEX_BITS(INDEX_BITS)
   ) u_train (
      .hist      (hist),
      .sel       (sel),
      .addr_ctr  (addr_ctr),
      .loc_ctr   (local_rdata_ff),
      .taken     (taken_ff),
      .pred      (pred),
      .use_addr  (use_addr),
      .hist_next (hist_next),
      .sel_next  (sel_next),
      .addr_next (addr_next),
      .loc_next  (loc_next)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign advance   = (state_ff == ST_LOCAL) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      slot_re      = 1'b0;
      local_re     = 1'b0;
      slot_we      = 1'b0;
      local_we     = 1'b0;
      slot_waddr   = slot_ff;
      slot_wdata   = {hist_next, addr_next, sel_next};
      local_waddr  = hist;
      local_wdata  = loc_next;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_CLEAR: begin
            slot_we     = 1'b1;
            local_we    = 1'b1;
            slot_waddr  = clr_ff;
            local_waddr = clr_ff;
            slot_wdata  = '0;
            local_wdata = CTR_ZERO;
            clr_in      = clr_ff + 1'b1;
            if (&clr_ff) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               slot_re  = 1'b1;
               state_in = ST_SLOT;
            end
         end
         ST_SLOT: begin
            local_re = 1'b1;
            state_in = ST_LOCAL;
         end
         ST_LOCAL: begin
            if (advance) begin
               slot_we      = op_ff;
               local_we     = op_ff && !use_addr;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
            clr_in   = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff    <= req_operation;
         taken_ff <= req_actual_taken;
         slot_ff  <= req_branch_address[INDEX_BITS+1:2];
      end
      if (advance) begin
         rsp_pred_ff <= pred;
         rsp_addr_ff <= use_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (slot_we) slot_mem[slot_waddr] <= slot_wdata;
      if (slot_re) slot_rdata_ff <= slot_mem[req_branch_address[INDEX_BITS+1:2]];
   end

   always_ff @(posedge clock) begin
      if (local_we) local_mem[local_waddr] <= local_wdata;
      if (local_re) local_rdata_ff <= local_mem[hist];
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_predict_taken      = rsp_pred_ff;
   assign rsp_chose_address_side = rsp_addr_ff;

   a_accept_reads_slot: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_SLOT))
      else $error("accepted word did not start slot read");

   a_slot_then_local: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SLOT) |=> (state_ff == ST_LOCAL))
      else $error("slot read not followed by local read");

   a_rsp_from_local: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_LOCAL))
      else $error("result raised outside local stage");

   a_no_write_when_idle: assert property (@(posedge clock) disable iff (reset)
      (slot_we || local_we) |-> (state_ff == ST_CLEAR || state_ff == ST_LOCAL))
      else $error("table write outside clear or write-back");

endmodule

// ===== test/tbp_checker.sv =====
`timescale 1ns / 100ps

module tbp_checker
   import tbp_pkg::*;
#(
   parameter int INDEX_BITS = 10
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic        req_operation,
   input  logic [31:0] req_branch_address,
   input  logic        req_actual_taken,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic        rsp_predict_taken,
   input  logic        rsp_chose_address_side,
   output int          fail_count,
   output int          pending
);

   localparam int SLOTS = 1 << INDEX_BITS;

   typedef struct packed {
      logic predict_taken;
      logic chose_address_side;
   } guess_type;

   logic [INDEX_BITS-1:0] history_mem [SLOTS];
   ctr_type               local_mem   [SLOTS];
   ctr_type               address_mem [SLOTS];
   ctr_type               chooser_mem [SLOTS];
   guess_type             guesses_q   [$];

   function automatic ctr_type nudge(input ctr_type c, input logic up);
      if (up) return (c == CTR_MAX) ? c : ctr_type'(c + 2'd1);
      return (c == CTR_ZERO) ? c : ctr_type'(c - 2'd1);
   endfunction

   task automatic report(input string what, input logic got, input logic want);
      $display("%0t: %s got %b want %b", $realtime, what, got, want);
      fail_count++;
   endtask

   task automatic absorb_word(input logic is_update, input logic [31:0] addr,
                              input logic taken);
      logic [INDEX_BITS-1:0] slot;
      logic [INDEX_BITS-1:0] hist;
      ctr_type               chooser;
      ctr_type               addr_ctr;
      ctr_type               loc_ctr;
      logic                  addr_side;
      logic                  addr_guess;
      logic                  loc_guess;
      slot       = addr[INDEX_BITS+1:2];
      hist       = history_mem[slot];
      chooser    = chooser_mem[slot];
      addr_ctr   = address_mem[slot];
      loc_ctr    = local_mem[hist];
      addr_side  = chooser[CTR_UPPER];
      addr_guess = addr_ctr[CTR_UPPER];
      loc_guess  = loc_ctr[CTR_UPPER];
      guesses_q.push_back('{addr_side ? addr_guess : loc_guess, addr_side});
      if (is_update) begin
         history_mem[slot] = INDEX_BITS'({hist, taken});
         if (addr_side) begin
            chooser_mem[slot] = nudge(chooser, addr_guess == taken);
            address_mem[slot] = nudge(addr_ctr, taken);
         end else begin
            chooser_mem[slot] = nudge(chooser, loc_guess != taken);
            local_mem[hist]   = nudge(loc_ctr, taken);
         end
      end
   endtask

   always @(posedge clock) begin
      guess_type want;
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            history_mem[i] = '0;
            local_mem[i]   = CTR_ZERO;
            address_mem[i] = CTR_ZERO;
            chooser_mem[i] = CTR_ZERO;
         end
         guesses_q.delete();
         fail_count = 0;
      end else begin
         if (req_valid && req_ready)
            absorb_word(req_operation, req_branch_address, req_actual_taken);
         if (rsp_valid && rsp_ready) begin
            if (guesses_q.size() == 0) begin
               report("unexpected word, predict_taken", rsp_predict_taken, 1'bx);
            end else begin
               want = guesses_q.pop_front();
               if (rsp_predict_taken !== want.predict_taken)
                  report("predict_taken", rsp_predict_taken, want.predict_taken);
               if (rsp_chose_address_side !== want.chose_address_side)
                  report("chose_address_side", rsp_chose_address_side,
                         want.chose_address_side);
            end
         end
      end
      pending = guesses_q.size();
   end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps

module tb;

   localparam int   INDEX_BITS  = 10;
   localparam logic OP_PREDICT  = 1'b0;
   localparam logic OP_UPDATE   = 1'b1;
   localparam int   WORD_COUNT  = 1800;
   localparam int   CYCLE_LIMIT = 200000;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic        req_operation;
   logic [31:0] req_branch_address;
   logic        req_actual_taken;
   logic        rsp_valid;
   logic        rsp_ready;
   logic        rsp_predict_taken;
   logic        rsp_chose_address_side;
   logic        calm;
   int          fail_count;
   int          pending;
   int          cycles = 0;

   tournament_branch_predictor_unit #(.INDEX_BITS(INDEX_BITS)) uut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_operation         (req_operation),
      .req_branch_address    (req_branch_address),
      .req_actual_taken      (req_actual_taken),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_predict_taken     (rsp_predict_taken),
      .rsp_chose_address_side(rsp_chose_address_side)
   );

   tbp_checker #(.INDEX_BITS(INDEX_BITS)) u_checker (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_operation         (req_operation),
      .req_branch_address    (req_branch_address),
      .req_actual_taken      (req_actual_taken),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_predict_taken     (rsp_predict_taken),
      .rsp_chose_address_side(rsp_chose_address_side),
      .fail_count            (fail_count),
      .pending               (pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("tournament_branch_predictor_unit: mismatch");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_ready <= calm || $urandom_range(0, 99) >= 26;
   end

   task automatic send_word(input logic op, input logic [31:0] addr, input logic taken);
      while (!calm && $urandom_range(0, 99) < 26) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_operation      <= op;
      req_branch_address <= addr;
      req_actual_taken   <= taken;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   initial begin
      logic [INDEX_BITS-1:0] hot_slots [8];
      logic                  flip      [8];
      logic [31:0]           addr;
      logic                  op;
      logic                  taken;
      int                    k;
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_operation      = OP_PREDICT;
      req_branch_address = '0;
      req_actual_taken   = 1'b0;
      rsp_ready          = 1'b0;
      calm               = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      send_word(OP_PREDICT, 32'h0000_0000, 1'b0);
      send_word(OP_PREDICT, 32'hFFFF_FFFF, 1'b1);
      repeat (12) send_word(OP_UPDATE, 32'h0000_0014, 1'b1);
      repeat (4) send_word(OP_UPDATE, 32'hFFFF_F017, 1'b0);
      send_word(OP_PREDICT, 32'h0000_0014, 1'b0);
      send_word(OP_UPDATE, 32'hFFFF_FFFC, 1'b1);
      send_word(OP_UPDATE, 32'h0000_0003, 1'b0);
      send_word(OP_PREDICT, 32'hFFFF_FFFF, 1'b0);

      hot_slots[0] = '0;
      hot_slots[1] = '1;
      for (int i = 2; i < 8; i++)
         hot_slots[i] = INDEX_BITS'($urandom_range(0, (1 << INDEX_BITS) - 1));
      for (int i = 0; i < 8; i++) flip[i] = 1'b0;

      for (int n = 0; n < WORD_COUNT; n++) begin
         calm <= (n >= 700 && n < 1000);
         k    = $urandom_range(0, 7);
         addr = $urandom();
         if ($urandom_range(0, 99) < 75) addr[INDEX_BITS+1:2] = hot_slots[k];
         op = ($urandom_range(0, 99) < 80) ? OP_UPDATE : OP_PREDICT;
         case (k % 3)
            0: begin
               taken = $urandom_range(0, 99) < 90;
            end
            1: begin
               flip[k] = ~flip[k];
               taken   = flip[k];
            end
            default: begin
               taken = 1'($urandom_range(0, 1));
            end
         endcase
         send_word(op, addr, taken);
      end
      req_valid <= 1'b0;

      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (fail_count == 0) begin
         $display("tournament_branch_predictor_unit: match");
      end else begin
         $display("tournament_branch_predictor_unit: mismatch");
      end
      $finish;
   end

endmodule
